// ===== hw/rtl/bsa_pkg.sv =====
package bsa_pkg;

  localparam int unsigned DEF_MAX_SLOTS = 1024;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned SIZE_W        = 16;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned IDX_OUT_W     = 10;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BIT_W         = $clog2(WORD_W);
  localparam int unsigned DIV_STEPS     = 2;
  localparam int unsigned DIV_CYCLES    = ADDR_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_CYCLES);
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [SIZE_W-1:0]  ITEM_SIZE_RST  = SIZE_W'(1);
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = COUNT_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_CLEAR,
    CMD_NONE
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_OOM,
    ST_BAD_SIZE,
    ST_BAD_PTR,
    ST_DOUBLE
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_CLEAR,
    OP_REPORT
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE,
    CFG_ITEM_SIZE,
    CFG_SLOT_COUNT
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_EVAL,
    FR_DIV,
    FR_CHECK
  } front_state_e;

  typedef enum logic [2:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_ALLOC_SCAN,
    BK_ALLOC_MUL,
    BK_ALLOC_OUT,
    BK_FREE_CHK
  } back_state_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } job_t;

endpackage

// ===== hw/rtl/bsa_ram.sv =====
module bsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bsa_front.sv =====
module bsa_front import bsa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS,
  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS),
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [SIZE_W-1:0]  request_size_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [ADDR_W-1:0]  pool_base_i,
  input  logic [SIZE_W-1:0]  item_size_i,
  input  logic [CNT_W-1:0]   active_i,
  input  logic               full_i,
  output logic               push_o,
  output job_t               job_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic               busy_o
);

  front_state_e         state_q, state_d;
  cmd_e                 cmd_q;
  logic [SIZE_W-1:0]    req_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [ADDR_W-1:0]    dvd_q, dvd_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 ptr_ok;
  logic                 div_fail;
  logic [SIZE_W:0]      div_t;
  logic [SIZE_W-1:0]    div_r;
  logic [ADDR_W-1:0]    div_q;

  assign ptr_ok   = (addr_q >= pool_base_i) && (item_size_i != '0);
  assign div_fail = (rem_q != '0) || (dvd_q >= ADDR_W'(active_i));
  assign busy_o   = (state_q != FR_IDLE);

  // restoring divide, two quotient bits per cycle
  always_comb begin
    div_r = rem_q;
    div_q = dvd_q;
    div_t = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      div_t = {div_r, div_q[ADDR_W-1]};
      div_q = {div_q[ADDR_W-2:0], 1'b0};
      if (div_t >= {1'b0, item_size_i}) begin
        div_t    = div_t - {1'b0, item_size_i};
        div_q[0] = 1'b1;
      end
      div_r = div_t[SIZE_W-1:0];
    end
    rem_d = div_r;
    dvd_d = div_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (accept_i) begin
          state_d = FR_EVAL;
        end
      end
      FR_EVAL: begin
        if (cmd_q == CMD_FREE && ptr_ok) begin
          state_d = FR_DIV;
        end else if (!full_i) begin
          state_d = FR_IDLE;
        end
      end
      FR_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_d = FR_CHECK;
        end
      end
      FR_CHECK: begin
        if (!full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    push_o        = 1'b0;
    job_o.op      = OP_REPORT;
    job_o.status  = ST_OK;
    slot_o        = '0;
    case (state_q)
      FR_EVAL: begin
        case (cmd_q)
          CMD_ALLOC: begin
            push_o = !full_i;
            if (req_q == item_size_i) begin
              job_o.op = OP_ALLOC;
            end else begin
              job_o.status = ST_BAD_SIZE;
            end
          end
          CMD_FREE: begin
            push_o       = !full_i && !ptr_ok;
            job_o.status = ST_BAD_PTR;
          end
          CMD_CLEAR: begin
            push_o   = !full_i;
            job_o.op = OP_CLEAR;
          end
          default: begin
            push_o = !full_i;
          end
        endcase
      end
      FR_CHECK: begin
        push_o = !full_i;
        if (div_fail) begin
          job_o.status = ST_BAD_PTR;
        end else begin
          job_o.op = OP_FREE;
          slot_o   = SLOT_W'(dvd_q);
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FR_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && accept_i) begin
      cmd_q  <= cmd_e'(cmd_i);
      req_q  <= request_size_i;
      addr_q <= address_i;
    end
    if (state_q == FR_EVAL) begin
      dvd_q <= addr_q - pool_base_i;
      rem_q <= '0;
    end else if (state_q == FR_DIV) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> state_q == FR_IDLE)
    else $error("beat accepted while front busy");

endmodule

// ===== hw/rtl/bsa_queue.sv =====
module bsa_queue import bsa_pkg::*; #(
  parameter int unsigned SLOT_W = 10,
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  job_t              job_i,
  input  logic [SLOT_W-1:0] slot_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output job_t              job_o,
  output logic [SLOT_W-1:0] slot_o
);

  job_t              job_q  [QUEUE_DEPTH];
  logic [SLOT_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = job_q[rd_ptr_q];
  assign slot_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_q[wr_ptr_q]  <= job_i;
      slot_q[wr_ptr_q] <= slot_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/bsa_back.sv =====
module bsa_back import bsa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS,
  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS),
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ADDR_W-1:0]    pool_base_i,
  input  logic [SIZE_W-1:0]    item_size_i,
  input  logic [CNT_W-1:0]     active_i,
  input  logic                 sweep_i,
  input  logic                 empty_i,
  input  job_t                 job_i,
  input  logic [SLOT_W-1:0]    slot_i,
  output logic                 pop_o,
  output logic                 sweeping_o,
  output logic                 valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [ADDR_W-1:0]    slot_address_o,
  output logic [IDX_OUT_W-1:0] slot_index_o
);

  localparam int unsigned ROWS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned RB_W  = ROW_W + BIT_W;
  localparam int unsigned LW    = ((RB_W > CNT_W) ? RB_W : CNT_W) + 1;
  localparam int unsigned PW    = SLOT_W + SIZE_W;
  localparam int unsigned XW    = SLOT_W + BIT_W;

  back_state_e          state_q, state_d;
  logic [ROW_W-1:0]     row_q;
  logic                 clr_rep_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [ADDR_W-1:0]    prod_q;
  logic                 valid_q;
  status_e              status_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [IDX_OUT_W-1:0] idx_q;

  logic                 res_valid_d;
  status_e              res_status_d;
  logic [ADDR_W-1:0]    res_addr_d;
  logic [IDX_OUT_W-1:0] res_idx_d;

  logic                 ram_we;
  logic [ROW_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, rdata;

  logic [LW-1:0]        row_base, n_ext, left;
  logic [WORD_W-1:0]    row_mask, free_bits, lowest;
  logic [BIT_W-1:0]     bit_sel;
  logic                 found, last_row, sweep_last;
  logic [SLOT_W-1:0]    found_slot;
  logic [XW-1:0]        in_ext, q_ext;
  logic [ROW_W-1:0]     in_row, q_row;
  logic [BIT_W-1:0]     q_bit;
  logic                 q_used;
  logic [ADDR_W-1:0]    slot_wide;

  bsa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign row_base   = LW'({row_q, {BIT_W{1'b0}}});
  assign n_ext      = LW'(active_i);
  assign left       = n_ext - row_base;
  assign last_row   = (n_ext <= row_base + LW'(WORD_W));
  assign sweep_last = (row_q == ROW_W'(ROWS - 1));

  always_comb begin
    if (n_ext <= row_base) begin
      row_mask = '0;
    end else if (left >= LW'(WORD_W)) begin
      row_mask = '1;
    end else begin
      row_mask = (WORD_W'(1) << left) - WORD_W'(1);
    end
  end

  assign free_bits = ~rdata & row_mask;
  assign lowest    = free_bits & (~free_bits + WORD_W'(1));
  assign found     = (free_bits != '0);

  always_comb begin
    bit_sel = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (lowest[k]) begin
        bit_sel = bit_sel | BIT_W'(k);
      end
    end
  end

  assign found_slot = SLOT_W'({row_q, bit_sel});
  assign in_ext     = XW'(slot_i);
  assign in_row     = ROW_W'(in_ext >> BIT_W);
  assign q_ext      = XW'(slot_q);
  assign q_row      = ROW_W'(q_ext >> BIT_W);
  assign q_bit      = q_ext[BIT_W-1:0];
  assign q_used     = rdata[q_bit];
  assign slot_wide  = ADDR_W'(slot_q);

  assign pop_o      = (state_q == BK_IDLE) && !sweep_i && !empty_i;
  assign sweeping_o = (state_q == BK_SWEEP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_SWEEP: begin
        if (sweep_last) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (sweep_i) begin
          state_d = BK_SWEEP;
        end else if (!empty_i) begin
          case (job_i.op)
            OP_ALLOC: state_d = BK_ALLOC_SCAN;
            OP_FREE:  state_d = BK_FREE_CHK;
            OP_CLEAR: state_d = BK_SWEEP;
            default:  state_d = BK_IDLE;
          endcase
        end
      end
      BK_ALLOC_SCAN: begin
        if (found) begin
          state_d = BK_ALLOC_MUL;
        end else if (last_row) begin
          state_d = BK_IDLE;
        end
      end
      BK_ALLOC_MUL: state_d = BK_ALLOC_OUT;
      BK_ALLOC_OUT: state_d = BK_IDLE;
      BK_FREE_CHK:  state_d = BK_IDLE;
      default:      state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = row_q;
    ram_wdata    = '0;
    ram_raddr    = '0;
    res_valid_d  = 1'b0;
    res_status_d = ST_OK;
    res_addr_d   = '0;
    res_idx_d    = '0;
    case (state_q)
      BK_SWEEP: begin
        ram_we = 1'b1;
        if (sweep_last && clr_rep_q) begin
          res_valid_d = 1'b1;
        end
      end
      BK_IDLE: begin
        if (job_i.op == OP_FREE) begin
          ram_raddr = in_row;
        end
        if (pop_o && job_i.op == OP_REPORT) begin
          res_valid_d  = 1'b1;
          res_status_d = job_i.status;
        end
      end
      BK_ALLOC_SCAN: begin
        ram_raddr = row_q + 1'b1;
        if (found) begin
          ram_we    = 1'b1;
          ram_wdata = rdata | lowest;
        end else if (last_row) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_OOM;
        end
      end
      BK_ALLOC_OUT: begin
        res_valid_d = 1'b1;
        res_addr_d  = pool_base_i + prod_q;
        res_idx_d   = slot_wide[IDX_OUT_W-1:0];
      end
      BK_FREE_CHK: begin
        res_valid_d = 1'b1;
        ram_waddr   = q_row;
        if (q_used) begin
          ram_we    = 1'b1;
          ram_wdata = rdata & ~(WORD_W'(1) << q_bit);
          res_idx_d = slot_wide[IDX_OUT_W-1:0];
        end else begin
          res_status_d = ST_DOUBLE;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_SWEEP;
      row_q     <= '0;
      clr_rep_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= res_valid_d;
      case (state_q)
        BK_SWEEP: begin
          row_q <= sweep_last ? '0 : row_q + 1'b1;
        end
        BK_IDLE: begin
          row_q <= '0;
          if (sweep_i) begin
            clr_rep_q <= 1'b0;
          end else if (pop_o) begin
            clr_rep_q <= (job_i.op == OP_CLEAR);
          end
        end
        BK_ALLOC_SCAN: begin
          row_q <= row_q + 1'b1;
        end
        default: begin
          row_q <= row_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      slot_q <= slot_i;
    end else if (state_q == BK_ALLOC_SCAN && found) begin
      slot_q <= found_slot;
    end
    if (state_q == BK_ALLOC_MUL) begin
      prod_q <= ADDR_W'(PW'(slot_q) * PW'(item_size_i));
    end
    status_q <= res_status_d;
    addr_q   <= res_addr_d;
    idx_q    <= res_idx_d;
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign slot_address_o = addr_q;
  assign slot_index_o   = idx_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != ST_OK) |-> (addr_q == '0 && idx_q == '0))
    else $error("error beat carries nonzero payload");

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == BK_SWEEP || state_q == BK_ALLOC_SCAN ||
                state_q == BK_FREE_CHK))
    else $error("map written outside sweep, scan or free");

  a_alloc_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_ALLOC_OUT |=> (valid_q && status_q == ST_OK))
    else $error("granted slot not reported");

endmodule

// ===== hw/rtl/bitmap_slot_allocator.sv =====
// Slot allocator over a one-bit-per-slot occupancy map held in a RAM of 32-bit rows.
// A command is taken when start is high and busy is low; exactly one result comes
// back per command, in order, as a one-cycle valid_o strobe that cannot be held off.
// A front stage decodes and checks each command and a two-entry queue feeds the map
// engine, so the next command is taken while the map engine still works. Allocate
// searches the map row by row for the first free slot, over up to ceil(active/32)
// rows. Free runs the address divider (two quotient bits per cycle) that checks
// alignment. Clear and every slot_count write sweep the whole map, one row per
// cycle over its ceil(MAX_SLOTS/32) rows (32 by default), and the same sweep runs
// after reset; busy stays high during it. The user must write configuration only
// while nothing is pending; the block itself does not enforce it.
module bitmap_slot_allocator import bsa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [SIZE_W-1:0]     request_size_i,
  input  logic [ADDR_W-1:0]     address_i,
  output logic                  valid_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [ADDR_W-1:0]     slot_address_o,
  output logic [IDX_OUT_W-1:0]  slot_index_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [ADDR_W-1:0]  pool_base_q;
  logic [SIZE_W-1:0]  item_size_q;
  logic [COUNT_W-1:0] slot_count_q;
  logic [CNT_W-1:0]   active;
  logic               accept;
  logic               sweep_req;
  logic               front_busy;
  logic               sweeping;
  logic               push, pop, full, empty;
  job_t               push_job, head_job;
  logic [SLOT_W-1:0]  push_slot, head_slot;

  assign active = (CMP_W'(slot_count_q) > CMP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                             : CNT_W'(slot_count_q);
  assign busy      = front_busy || sweeping;
  assign accept    = start && !busy;
  assign sweep_req = cfg_we_i && (cfg_reg_e'(cfg_index_i) == CFG_SLOT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      item_size_q  <= ITEM_SIZE_RST;
      slot_count_q <= SLOT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_POOL_BASE:  pool_base_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_ITEM_SIZE:  item_size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_SLOT_COUNT: slot_count_q <= cfg_data_i[COUNT_W-1:0];
        default:        pool_base_q  <= pool_base_q;
      endcase
    end
  end

  bsa_front #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd_i),
    .request_size_i (request_size_i),
    .address_i      (address_i),
    .pool_base_i    (pool_base_q),
    .item_size_i    (item_size_q),
    .active_i       (active),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job),
    .slot_o         (push_slot),
    .busy_o         (front_busy)
  );

  bsa_queue #(
    .SLOT_W (SLOT_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .slot_i  (push_slot),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job),
    .slot_o  (head_slot)
  );

  bsa_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pool_base_i    (pool_base_q),
    .item_size_i    (item_size_q),
    .active_i       (active),
    .sweep_i        (sweep_req),
    .empty_i        (empty),
    .job_i          (head_job),
    .slot_i         (head_slot),
    .pop_o          (pop),
    .sweeping_o     (sweeping),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .slot_address_o (slot_address_o),
    .slot_index_o   (slot_index_o)
  );

endmodule

// ===== tb/bitmap_slot_allocator_tb.sv =====
`timescale 1ns / 100ps

module bitmap_slot_allocator_tb;
  import bsa_pkg::*;

  localparam int unsigned SLOTS        = DEF_MAX_SLOTS;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PRINT_LIMIT  = 200;

  typedef struct packed {
    status_e              status;
    logic [ADDR_W-1:0]    slot_address;
    logic [IDX_OUT_W-1:0] slot_index;
  } slot_result_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start          = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      cmd_i          = '0;
  logic [SIZE_W-1:0]     request_size_i = '0;
  logic [ADDR_W-1:0]     address_i      = '0;
  logic                  valid_o;
  logic [STATUS_W-1:0]   status_o;
  logic [ADDR_W-1:0]     slot_address_o;
  logic [IDX_OUT_W-1:0]  slot_index_o;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // shadow pool state
  logic [SLOTS-1:0]   slot_map   = '0;
  logic [ADDR_W-1:0]  pool_base  = '0;
  logic [SIZE_W-1:0]  item_size  = ITEM_SIZE_RST;
  logic [COUNT_W-1:0] slot_count = SLOT_COUNT_RST;

  slot_result_t      expected_results[$];
  logic [ADDR_W-1:0] granted_addrs[$];
  int unsigned       err_count  = 0;
  int unsigned       idle_count = 0;

  bitmap_slot_allocator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .request_size_i (request_size_i),
    .address_i      (address_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .slot_address_o (slot_address_o),
    .slot_index_o   (slot_index_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned active_slots();
    return (slot_count > SLOTS) ? SLOTS : int'(slot_count);
  endfunction

  function automatic slot_result_t pool_step(cmd_e cmd, logic [SIZE_W-1:0] req,
                                            logic [ADDR_W-1:0] addr);
    slot_result_t      res;
    int unsigned       n;
    int unsigned       i;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] idx;
    bit                found;
    res.status       = ST_OK;
    res.slot_address = '0;
    res.slot_index   = '0;
    n                = active_slots();
    found            = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        if (req != item_size) begin
          res.status = ST_BAD_SIZE;
        end else begin
          for (i = 0; i < n; i++) begin
            if (!found && !slot_map[i]) begin
              found            = 1'b1;
              slot_map[i]      = 1'b1;
              res.slot_address = pool_base + ADDR_W'(i) * ADDR_W'(item_size);
              res.slot_index   = IDX_OUT_W'(i);
            end
          end
          if (!found) res.status = ST_OOM;
        end
      end
      CMD_FREE: begin
        if (addr < pool_base || item_size == '0) begin
          res.status = ST_BAD_PTR;
        end else begin
          offset = addr - pool_base;
          idx    = offset / ADDR_W'(item_size);
          if (offset % ADDR_W'(item_size) != '0 || idx >= n) begin
            res.status = ST_BAD_PTR;
          end else if (!slot_map[idx]) begin
            res.status = ST_DOUBLE;
          end else begin
            slot_map[idx]  = 1'b0;
            res.slot_index = idx[IDX_OUT_W-1:0];
          end
        end
      end
      CMD_CLEAR: slot_map = '0;
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("%0t: %s mismatch, got 0x%0h want 0x%0h", $time, field, got, want);
  endtask

  task automatic send_cmd(cmd_e cmd, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] addr);
    slot_result_t res;
    start          <= 1'b1;
    cmd_i          <= cmd;
    request_size_i <= req;
    address_i      <= addr;
    do @(posedge clk_i); while (busy);
    res = pool_step(cmd, req, addr);
    expected_results.push_back(res);
    if (cmd == CMD_CLEAR) granted_addrs.delete();
    if (cmd == CMD_ALLOC && res.status == ST_OK) granted_addrs.push_back(res.slot_address);
  endtask

  task automatic pause_cycles(int unsigned n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic set_pool(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size,
                          logic [COUNT_W-1:0] count);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_POOL_BASE;
    cfg_data_i  <= CFG_DATA_W'(base);
    @(posedge clk_i);
    cfg_index_i <= CFG_ITEM_SIZE;
    cfg_data_i  <= CFG_DATA_W'(size);
    @(posedge clk_i);
    cfg_index_i <= CFG_SLOT_COUNT;
    cfg_data_i  <= CFG_DATA_W'(count);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pool_base  = base;
    item_size  = size;
    slot_count = count;
    slot_map   = '0;
    granted_addrs.delete();
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    slot_result_t want;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", ADDR_W'(status_o), '0);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", ADDR_W'(status_o), ADDR_W'(want.status));
        if (slot_address_o !== want.slot_address)
          report_mismatch("slot_address", slot_address_o, want.slot_address);
        if (slot_index_o !== want.slot_index)
          report_mismatch("slot_index", ADDR_W'(slot_index_o), ADDR_W'(want.slot_index));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o || cfg_we_i)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("bitmap_slot_allocator_tb: done, errors");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_cmd(CMD_ALLOC, 16'd1, 32'h0);
    send_cmd(CMD_ALLOC, 16'd1, 32'hFFFF_FFFF);
    send_cmd(CMD_FREE, 16'hFFFF, 32'h1);
    send_cmd(CMD_FREE, 16'h0, 32'h1);
    send_cmd(CMD_FREE, 16'h0, 32'hFFFF_FFFF);
  endtask

  task automatic test_alloc_free();
    set_pool(32'h1000, 16'h0030, 11'd2);
    send_cmd(CMD_ALLOC, 16'h0031, 32'h0);
    send_cmd(CMD_ALLOC, 16'h0030, 32'h0);
    send_cmd(CMD_ALLOC, 16'h0030, 32'h0);
    send_cmd(CMD_ALLOC, 16'h0030, 32'h0);
    send_cmd(CMD_FREE, 16'h0, 32'h1018);
    send_cmd(CMD_FREE, 16'h0, 32'h0FFF);
    send_cmd(CMD_FREE, 16'h0, 32'h1060);
    send_cmd(CMD_FREE, 16'h0, 32'h1030);
  endtask

  task automatic test_empty_pool();
    set_pool(32'h0, 16'hFFFF, 11'd0);
    send_cmd(CMD_ALLOC, 16'hFFFF, 32'h0);
    send_cmd(CMD_FREE, 16'hFFFF, 32'h0);
  endtask

  task automatic test_zero_item_size();
    set_pool(32'hABCD_0000, 16'h0, 11'd4);
    send_cmd(CMD_ALLOC, 16'h0, 32'h0);
    send_cmd(CMD_FREE, 16'h0, 32'hABCD_0000);
  endtask

  task automatic test_wrapped_address();
    set_pool(32'hFFFF_FF00, 16'h0040, 11'd8);
    repeat (5) send_cmd(CMD_ALLOC, 16'h0040, 32'h0);
    send_cmd(CMD_FREE, 16'h0, 32'h0);
    send_cmd(CMD_FREE, 16'h0, 32'hFFFF_FF40);
  endtask

  task automatic test_clear_and_reserved();
    send_cmd(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_CLEAR, 16'h0040, 32'h0);
    send_cmd(CMD_ALLOC, 16'h0040, 32'h0);
  endtask

  task automatic test_count_above_capacity();
    set_pool(32'h0, 16'h0004, 11'd2047);
    send_cmd(CMD_FREE, 16'h0, 32'h1000);
    send_cmd(CMD_ALLOC, 16'h0004, 32'h0);
  endtask

  task automatic test_random();
    int unsigned       sent;
    int unsigned       k;
    int unsigned       phase_len;
    int unsigned       burst_left;
    int unsigned       gap_max;
    int unsigned       sel;
    int unsigned       pick;
    int unsigned       n;
    int unsigned       j;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0] addr;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: base = '0;
        1: base = '1;
        2: base = 32'h8000_0000;
        3: base = 32'hFFFF_0000 | ADDR_W'($urandom_range(0, 16'hFFFF));
        default: base = $urandom;
      endcase
      case ($urandom_range(0, 11))
        0: size = 16'd1;
        1: size = 16'hFFFF;
        2: size = 16'h0;
        3, 4: size = SIZE_W'($urandom_range(2, 8));
        5: size = 16'h1000;
        default: size = SIZE_W'($urandom_range(1, 16'hFFFF));
      endcase
      case ($urandom_range(0, 11))
        0: count = 11'd0;
        1: count = 11'd1;
        2: count = COUNT_W'($urandom_range(31, 33));
        3: count = 11'd1024;
        4: count = COUNT_W'($urandom_range(1025, 2047));
        5: count = COUNT_W'($urandom_range(63, 65));
        default: count = COUNT_W'($urandom_range(2, 100));
      endcase
      set_pool(base, size, count);
      phase_len  = $urandom_range(60, 160);
      gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      n          = active_slots();
      for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          send_cmd(CMD_ALLOC, ($urandom_range(0, 15) == 0) ? SIZE_W'($urandom) : item_size,
                   $urandom);
        end else if (sel < 88) begin
          pick = $urandom_range(0, 99);
          if (pick < 55 && granted_addrs.size() != 0) begin
            j    = $urandom_range(0, granted_addrs.size() - 1);
            addr = granted_addrs[j];
            granted_addrs.delete(j);
          end else if (pick < 75) begin
            addr = pool_base + ADDR_W'($urandom_range(0, n + 2)) * ADDR_W'(item_size);
          end else if (pick < 87) begin
            addr = pool_base + ADDR_W'($urandom_range(0, n)) * ADDR_W'(item_size)
                   + ADDR_W'($urandom_range(1, 3));
          end else if (pick < 93) begin
            addr = pool_base - ADDR_W'($urandom_range(1, 64));
          end else begin
            addr = $urandom;
          end
          send_cmd(CMD_FREE, SIZE_W'($urandom), addr);
        end else if (sel < 90) begin
          send_cmd(CMD_CLEAR, SIZE_W'($urandom), $urandom);
        end else if (sel < 94) begin
          send_cmd(CMD_NONE, SIZE_W'($urandom), $urandom);
        end else begin
          send_cmd(cmd_e'($urandom_range(0, 3)), SIZE_W'($urandom), $urandom);
        end
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          pause_cycles($urandom_range(0, gap_max));
          burst_left = $urandom_range(1, 16);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();
    test_reset_defaults();
    test_alloc_free();
    test_empty_pool();
    test_zero_item_size();
    test_wrapped_address();
    test_clear_and_reserved();
    test_count_above_capacity();
    test_random();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("bitmap_slot_allocator_tb: done, clean");
    end else begin
      $display("bitmap_slot_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule
